// ===== rtl/qrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// qrsp_pkg
// Shared constants for the queue-relaxation shortest path block: sizes,
// widths, distance codes, action codes and register indices.
// ----------------------------------------------------------------------------
package qrsp_pkg;

	localparam int NODE_W      = 10;
	localparam int NODE_DEPTH  = 1 << NODE_W;
	localparam int CNT_W       = NODE_W + 1;
	localparam int EDGE_AW     = 13;
	localparam int LINK_W      = EDGE_AW + 1;
	localparam int WEIGHT_BITS = 16;
	localparam int DIST_W      = 32;
	localparam int ES_W        = NODE_W + WEIGHT_BITS + LINK_W;

	localparam logic [DIST_W-1:0] UNREACHED = {DIST_W{1'b1}};
	localparam logic [DIST_W-1:0] SAT_DIST  = {{(DIST_W-1){1'b1}}, 1'b0};
	localparam logic [CNT_W-1:0]  LIVE_MAX  = CNT_W'(NODE_DEPTH);
	localparam logic [LINK_W-1:0] EDGE_MAX  = LINK_W'(1 << EDGE_AW);

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_EDGE  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic CFG_SOURCE = 1'b0;
	localparam logic CFG_NODES  = 1'b1;

endpackage

// ===== rtl/qrsp_ram.sv =====
// ----------------------------------------------------------------------------
// qrsp_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. No reset on contents.
// ----------------------------------------------------------------------------
module qrsp_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [1 << ADDR_W];
	logic [DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ===== rtl/queue_relaxation_shortest_path.sv =====
// ----------------------------------------------------------------------------
// queue_relaxation_shortest_path
// Single-source shortest paths over a stored graph by deque relaxation with
// the small-label-first rule, answering minimum-distance queries.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. action selects
//   clear (new case), add edge (edge_tail -> edge_head, edge_weight) or query
//   (query_node, last_query). Configuration (source_node, node_count) is
//   written through cfg_we / cfg_index / cfg_wdata, only while idle.
// Sequencing:
//   Clear: a sweep over the node memories (list heads, distances, queued
//   flags), one entry per cycle. The same sweep runs after reset; busy
//   stays high throughout the sweep.
//   Add edge: the list head is read on the accepting edge; then, if both
//   nodes are in range and the store has room, S_EADD does the edge and
//   list head writes. Query: when distances are known, busy covers S_QFOLD
//   only; done follows in the next cycle. The first query of a case first
//   runs relaxation: S_INIT seeds the source, each pop takes S_POP, S_POPW
//   and S_ELINK, each edge scanned S_EREAD and S_RELAX, a push onto a
//   nonempty deque adds S_PUSH1 and S_PUSH2 (front compare), and S_RUNEND
//   and S_QFOLD close the run; the node, edge and deque memories are read in series.
//   A query with last_query set raises done for one cycle with min_distance
//   and unreachable; the receiver cannot stall, so results are never held.
// Reset: arst_n clears all control state, resets the registers to source 0,
//   1024 nodes, and starts the clear sweep.
// ----------------------------------------------------------------------------
module queue_relaxation_shortest_path (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        action,
	input  logic [qrsp_pkg::NODE_W-1:0]       edge_tail,
	input  logic [qrsp_pkg::NODE_W-1:0]       edge_head,
	input  logic [qrsp_pkg::WEIGHT_BITS-1:0]  edge_weight,
	input  logic [qrsp_pkg::NODE_W-1:0]       query_node,
	input  logic                              last_query,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [qrsp_pkg::CNT_W-1:0]        cfg_wdata,
	output logic                              done,
	output logic [qrsp_pkg::DIST_W-1:0]       min_distance,
	output logic                              unreachable
);

	import qrsp_pkg::*;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_EADD  = 4'd2;
	localparam logic [3:0] S_INIT  = 4'd3;
	localparam logic [3:0] S_POP   = 4'd4;
	localparam logic [3:0] S_POPW  = 4'd5;
	localparam logic [3:0] S_ELINK = 4'd6;
	localparam logic [3:0] S_EREAD = 4'd7;
	localparam logic [3:0] S_RELAX = 4'd8;
	localparam logic [3:0] S_PUSH1 = 4'd9;
	localparam logic [3:0] S_PUSH2 = 4'd10;
	localparam logic [3:0] S_RUNEND= 4'd11;
	localparam logic [3:0] S_QFOLD = 4'd12;

	logic [3:0]             state_q;
	logic [NODE_W-1:0]      clr_cnt_q;
	logic [LINK_W-1:0]      edge_cnt_q;
	logic [NODE_W-1:0]      front_q;
	logic [CNT_W-1:0]       fill_q;
	logic                   paths_done_q;
	logic [DIST_W-1:0]      run_min_q;
	logic [NODE_W-1:0]      src_q;
	logic [CNT_W-1:0]       ncnt_q;
	logic [DIST_W-1:0]      dv_q;
	logic [LINK_W-1:0]      e_q;
	logic [NODE_W-1:0]      to_q;
	logic [DIST_W-1:0]      d_q;
	logic [NODE_W-1:0]      qn_q;
	logic                   qlast_q;
	logic [NODE_W-1:0]      tail_q;
	logic [NODE_W-1:0]      head_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic                   done_q;
	logic [DIST_W-1:0]      min_q;
	logic                   unr_q;

	// memory ports
	logic              lh_we, dist_we, inq_we, dq_we, es_we;
	logic [NODE_W-1:0] lh_wa, lh_ra, dist_wa, dist_ra, inq_wa, inq_ra, dq_wa, dq_ra;
	logic [LINK_W-1:0] lh_wd, lh_rd;
	logic [DIST_W-1:0] dist_wd, dist_rd;
	logic              inq_wd, inq_rd;
	logic [NODE_W-1:0] dq_wd, dq_rd;
	logic [EDGE_AW-1:0] es_wa, es_ra;
	logic [ES_W-1:0]   es_wd, es_rd;

	// derived values
	logic [CNT_W-1:0]  live_n;
	logic              accept, src_ok, to_ok, tail_ok, head_ok, qn_ok;
	logic              relax_hit, push_ok;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] d_new;
	logic [NODE_W-1:0] es_to;
	logic [WEIGHT_BITS-1:0] es_w;
	logic [LINK_W-1:0] es_next;
	logic [LINK_W-1:0] e_dec;
	logic [NODE_W-1:0] back_idx;
	logic [DIST_W-1:0] fold_min;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign live_n  = (ncnt_q > LIVE_MAX) ? LIVE_MAX : ncnt_q;
	assign src_ok  = {1'b0, src_q} < live_n;
	assign to_ok   = {1'b0, to_q} < live_n;
	assign qn_ok   = {1'b0, qn_q} < live_n;
	assign tail_ok = {1'b0, edge_tail} < live_n;
	assign head_ok = {1'b0, edge_head} < live_n;

	assign es_to   = es_rd[ES_W-1 -: NODE_W];
	assign es_w    = es_rd[LINK_W +: WEIGHT_BITS];
	assign es_next = es_rd[LINK_W-1:0];

	// saturating path sum, never reaches the unreached code
	assign sum   = {1'b0, dv_q} + {{(DIST_W+1-WEIGHT_BITS){1'b0}}, es_w};
	assign d_new = (sum > {1'b0, SAT_DIST}) ? SAT_DIST : sum[DIST_W-1:0];

	assign relax_hit = to_ok && (d_q < dist_rd);
	assign push_ok   = relax_hit && !inq_rd && (fill_q < LIVE_MAX);
	assign e_dec     = e_q - 1'b1;
	assign back_idx  = front_q + fill_q[NODE_W-1:0];
	assign fold_min  = (qn_ok && (dist_rd < run_min_q)) ? dist_rd : run_min_q;

	// memory control
	always_comb begin
		lh_we = 1'b0; lh_wa = clr_cnt_q; lh_wd = '0; lh_ra = edge_tail;
		dist_we = 1'b0; dist_wa = clr_cnt_q; dist_wd = UNREACHED; dist_ra = qn_q;
		inq_we = 1'b0; inq_wa = clr_cnt_q; inq_wd = 1'b0; inq_ra = to_q;
		dq_we = 1'b0; dq_wa = back_idx; dq_wd = to_q; dq_ra = front_q;
		es_we = 1'b0; es_wa = edge_cnt_q[EDGE_AW-1:0];
		es_wd = {head_q, w_q, lh_rd}; es_ra = e_dec[EDGE_AW-1:0];
		case (state_q)
			S_CLR: begin
				lh_we = 1'b1; dist_we = 1'b1; inq_we = 1'b1;
			end
			S_IDLE: begin
				dist_ra = query_node;
			end
			S_EADD: begin
				es_we = 1'b1;
				lh_we = 1'b1; lh_wa = tail_q; lh_wd = edge_cnt_q + 1'b1;
			end
			S_INIT: begin
				if (src_ok) begin
					dist_we = 1'b1; dist_wa = src_q; dist_wd = '0;
					inq_we = 1'b1; inq_wa = src_q; inq_wd = 1'b1;
					dq_we = 1'b1; dq_wd = src_q;
				end
			end
			S_POPW: begin
				inq_we = 1'b1; inq_wa = dq_rd; inq_wd = 1'b0;
				lh_ra = dq_rd; dist_ra = dq_rd;
			end
			S_ELINK: begin
				es_ra = lh_rd[EDGE_AW-1:0] - 1'b1;
			end
			S_EREAD: begin
				dist_ra = es_to; inq_ra = es_to;
			end
			S_RELAX: begin
				if (relax_hit) begin
					dist_we = 1'b1; dist_wa = to_q; dist_wd = d_q;
				end
				if (push_ok && fill_q == '0) begin
					dq_we = 1'b1;
					inq_we = 1'b1; inq_wa = to_q; inq_wd = 1'b1;
				end
			end
			S_PUSH1: begin
				dist_ra = dq_rd;
			end
			S_PUSH2: begin
				dq_we = 1'b1;
				if (d_q < dist_rd) begin
					dq_wa = front_q - 1'b1;
				end
				inq_we = 1'b1; inq_wa = to_q; inq_wd = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_cnt_q    <= '0;
			edge_cnt_q   <= '0;
			front_q      <= '0;
			fill_q       <= '0;
			paths_done_q <= 1'b0;
			run_min_q    <= UNREACHED;
			src_q        <= '0;
			ncnt_q       <= LIVE_MAX;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_SOURCE) begin
					src_q <= cfg_wdata[NODE_W-1:0];
				end else begin
					ncnt_q <= cfg_wdata;
				end
			end
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == {NODE_W{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_CLEAR: begin
								clr_cnt_q    <= '0;
								edge_cnt_q   <= '0;
								front_q      <= '0;
								fill_q       <= '0;
								paths_done_q <= 1'b0;
								run_min_q    <= UNREACHED;
								state_q      <= S_CLR;
							end
							ACT_EDGE: begin
								if (tail_ok && head_ok && edge_cnt_q < EDGE_MAX) begin
									state_q <= S_EADD;
								end
							end
							ACT_QUERY: begin
								state_q <= paths_done_q ? S_QFOLD : S_INIT;
							end
							default: begin
							end
						endcase
					end
				end
				S_EADD: begin
					edge_cnt_q <= edge_cnt_q + 1'b1;
					state_q    <= S_IDLE;
				end
				S_INIT: begin
					if (src_ok) begin
						fill_q  <= fill_q + 1'b1;
						state_q <= S_POP;
					end else begin
						state_q <= S_RUNEND;
					end
				end
				S_POP: begin
					state_q <= (fill_q == '0) ? S_RUNEND : S_POPW;
				end
				S_POPW: begin
					front_q <= front_q + 1'b1;
					fill_q  <= fill_q - 1'b1;
					state_q <= S_ELINK;
				end
				S_ELINK: begin
					dv_q    <= dist_rd;
					state_q <= (lh_rd == '0) ? S_POP : S_EREAD;
				end
				S_EREAD: begin
					to_q    <= es_to;
					e_q     <= es_next;
					d_q     <= d_new;
					state_q <= S_RELAX;
				end
				S_RELAX: begin
					if (push_ok && fill_q != '0) begin
						state_q <= S_PUSH1;
					end else begin
						if (push_ok) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= (e_q == '0) ? S_POP : S_EREAD;
					end
				end
				S_PUSH1: begin
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (d_q < dist_rd) begin
						front_q <= front_q - 1'b1;
					end
					fill_q  <= fill_q + 1'b1;
					state_q <= (e_q == '0) ? S_POP : S_EREAD;
				end
				S_RUNEND: begin
					paths_done_q <= 1'b1;
					state_q      <= S_QFOLD;
				end
				S_QFOLD: begin
					if (qlast_q) begin
						done_q    <= 1'b1;
						run_min_q <= UNREACHED;
					end else begin
						run_min_q <= fold_min;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction payload and results, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			tail_q  <= edge_tail;
			head_q  <= edge_head;
			w_q     <= edge_weight;
			qn_q    <= query_node;
			qlast_q <= last_query;
		end
		if (state_q == S_QFOLD) begin
			unr_q <= (fold_min == UNREACHED);
			min_q <= (fold_min == UNREACHED) ? '0 : fold_min;
		end
	end

	assign done         = done_q;
	assign min_distance = min_q;
	assign unreachable  = unr_q;

	// memories
	qrsp_ram #(.DATA_W(LINK_W), .ADDR_W(NODE_W)) u_list_head (
		.clk(clk), .we(lh_we), .waddr(lh_wa), .wdata(lh_wd), .raddr(lh_ra), .rdata(lh_rd)
	);
	qrsp_ram #(.DATA_W(ES_W), .ADDR_W(EDGE_AW)) u_edge_store (
		.clk(clk), .we(es_we), .waddr(es_wa), .wdata(es_wd), .raddr(es_ra), .rdata(es_rd)
	);
	qrsp_ram #(.DATA_W(DIST_W), .ADDR_W(NODE_W)) u_distance (
		.clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(dist_ra),
		.rdata(dist_rd)
	);
	qrsp_ram #(.DATA_W(1), .ADDR_W(NODE_W)) u_in_queue (
		.clk(clk), .we(inq_we), .waddr(inq_wa), .wdata(inq_wd), .raddr(inq_ra), .rdata(inq_rd)
	);
	qrsp_ram #(.DATA_W(NODE_W), .ADDR_W(NODE_W)) u_work_deque (
		.clk(clk), .we(dq_we), .waddr(dq_wa), .wdata(dq_wd), .raddr(dq_ra), .rdata(dq_rd)
	);

	// checks
	a_done_from_fold: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_QFOLD && qlast_q)
		else $error("result strobe without a final query");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LIVE_MAX)
		else $error("deque fill beyond capacity");

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && unreachable |-> min_distance == '0)
		else $error("unreachable result carries a distance");

	a_run_needs_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUNEND |-> fill_q == '0)
		else $error("relaxation ended with queued nodes");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for queue_relaxation_shortest_path: drives clear,
// add-edge and query transactions, keeps its own shortest-path predictor and
// compares every done strobe against the oldest expected answer.
// ----------------------------------------------------------------------------
module tb;
	import qrsp_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;    // unused action code, ignored
	localparam int         STALL_LIMIT = 1000000;
	localparam int         ANS_DEPTH = 16;

	typedef struct packed {
		logic [DIST_W-1:0] min_d;
		logic              unr;
	} answer_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [1:0]             action = ACT_CLEAR;
	logic [NODE_W-1:0]      edge_tail = '0;
	logic [NODE_W-1:0]      edge_head = '0;
	logic [WEIGHT_BITS-1:0] edge_weight = '0;
	logic [NODE_W-1:0]      query_node = '0;
	logic                   last_query = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = CFG_SOURCE;
	logic [CNT_W-1:0]       cfg_wdata = '0;
	logic                   done;
	logic [DIST_W-1:0]      min_distance;
	logic                   unreachable;

	bit      failed = 1'b0;
	int      stall_cycles = 0;
	answer_t answer_fifo [ANS_DEPTH];
	int      ans_wr = 0;
	int      ans_rd = 0;

	queue_relaxation_shortest_path dut (.*);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shortest-path predictor: its own copy of the graph and the registers.
	// Links in node_list are edge number plus one, zero ends a list.
	// ------------------------------------------------------------------------
	logic [NODE_W-1:0]  sp_source = '0;
	logic [CNT_W-1:0]   sp_nodes = CNT_W'(NODE_DEPTH);
	int                 node_list [NODE_DEPTH];
	int                 arc_to [1 << EDGE_AW];
	int                 arc_w [1 << EDGE_AW];
	int                 arc_next [1 << EDGE_AW];
	int                 arc_cnt;
	logic [DIST_W-1:0]  node_dist [NODE_DEPTH];
	bit                 queued [NODE_DEPTH];
	int                 work [NODE_DEPTH];
	int                 work_head, work_fill;
	bit                 dist_known;
	logic [DIST_W-1:0]  fold_min;

	function automatic int live_count();
		return (sp_nodes < CNT_W'(NODE_DEPTH)) ? int'(sp_nodes) : NODE_DEPTH;
	endfunction

	function automatic void graph_clear();
		foreach (node_list[i]) begin
			node_list[i] = 0;
			node_dist[i] = UNREACHED;
			queued[i] = 1'b0;
		end
		arc_cnt = 0;
		work_head = 0;
		work_fill = 0;
		dist_known = 1'b0;
		fold_min = UNREACHED;
	endfunction

	// small-label-first: beat the front node's distance to jump the line
	function automatic void work_push(int v);
		if (work_fill >= NODE_DEPTH)
			return;
		if (work_fill > 0 && node_dist[v] < node_dist[work[work_head]]) begin
			work_head = (work_head + NODE_DEPTH - 1) % NODE_DEPTH;
			work[work_head] = v;
		end else begin
			work[(work_head + work_fill) % NODE_DEPTH] = v;
		end
		work_fill++;
		queued[v] = 1'b1;
	endfunction

	function automatic void relax_all();
		int            n;
		int            v, e, k, tgt;
		logic [DIST_W:0] sum;
		logic [DIST_W-1:0] d;
		n = live_count();
		if (int'(sp_source) >= n)
			return;
		node_dist[sp_source] = '0;
		work_push(sp_source);
		while (work_fill > 0) begin
			v = work[work_head];
			work_head = (work_head + 1) % NODE_DEPTH;
			work_fill--;
			queued[v] = 1'b0;
			e = node_list[v];
			while (e != 0) begin
				k = e - 1;
				tgt = arc_to[k];
				sum = {1'b0, node_dist[v]} + (DIST_W + 1)'(arc_w[k]);
				d = (sum > {1'b0, SAT_DIST}) ? SAT_DIST : sum[DIST_W-1:0];
				if (tgt < n && d < node_dist[tgt]) begin
					node_dist[tgt] = d;
					if (!queued[tgt])
						work_push(tgt);
				end
				e = arc_next[k];
			end
		end
	endfunction

	// applies one accepted transaction; queues an answer for a closing query
	function automatic void predict_transaction(logic [1:0] act, int tail, int head,
			int w, int q, logic lastq);
		int n;
		n = live_count();
		case (act)
			ACT_CLEAR: graph_clear();
			ACT_EDGE: begin
				if (tail < n && head < n && arc_cnt < (1 << EDGE_AW)) begin
					arc_to[arc_cnt] = head;
					arc_w[arc_cnt] = w & ((1 << WEIGHT_BITS) - 1);
					arc_next[arc_cnt] = node_list[tail];
					arc_cnt++;
					node_list[tail] = arc_cnt;
				end
			end
			ACT_QUERY: begin
				if (!dist_known) begin
					relax_all();
					dist_known = 1'b1;
				end
				if (q < n && node_dist[q] < fold_min)
					fold_min = node_dist[q];
				if (lastq) begin
					if (fold_min == UNREACHED)
						answer_fifo[ans_wr % ANS_DEPTH] = '{min_d: '0, unr: 1'b1};
					else
						answer_fifo[ans_wr % ANS_DEPTH] = '{min_d: fold_min, unr: 1'b0};
					ans_wr++;
					fold_min = UNREACHED;
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Driving side. Inputs move on the falling edge; a transaction is taken
	// at the rising edge where start is high and busy is low.
	// ------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send(logic [1:0] act, int tail = 0, int head = 0, int w = 0,
			int q = 0, logic lastq = 1'b0, int gap = -1);
		if (gap < 0)
			gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start       <= 1'b1;
		action      <= act;
		edge_tail   <= NODE_W'(tail);
		edge_head   <= NODE_W'(head);
		edge_weight <= WEIGHT_BITS'(w);
		query_node  <= NODE_W'(q);
		last_query  <= lastq;
		do
			@(posedge clk);
		while (busy);
		predict_transaction(act, tail, head, w, q, lastq);
	endtask

	// drop start and let the block drain before touching the registers
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (ans_wr != ans_rd || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CNT_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SOURCE)
			sp_source = NODE_W'(value);
		else
			sp_nodes = CNT_W'(value);
	endtask

	task automatic configure(int src, int nodes);
		settle();
		write_reg(CFG_SOURCE, src);
		write_reg(CFG_NODES, nodes);
	endtask

	// ------------------------------------------------------------------------
	// Result checking: done can not be held off, so every strobe counts.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (ans_wr == ans_rd) begin
				$error("unexpected result: min_distance=%0d unreachable=%0b",
					min_distance, unreachable);
				failed = 1'b1;
			end else begin
				answer_t exp_a;
				exp_a = answer_fifo[ans_rd % ANS_DEPTH];
				ans_rd++;
				if (min_distance !== exp_a.min_d) begin
					$error("min_distance: expected %0d, got %0d", exp_a.min_d, min_distance);
					failed = 1'b1;
				end
				if (unreachable !== exp_a.unr) begin
					$error("unreachable: expected %0b, got %0b", exp_a.unr, unreachable);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: cycles with neither an accepted transaction nor a result.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Registers at reset values: source 0 of 1024 nodes, empty graph.
	task automatic test_reset_state();
		send(ACT_QUERY, .q(0), .lastq(1'b1));
		send(ACT_QUERY, .q(5), .lastq(1'b1));
		send(ACT_QUERY, .q(1023), .lastq(1'b1));
	endtask

	task automatic test_directed();
		configure(2, 8);
		send(ACT_CLEAR);
		send(ACT_EDGE, 2, 3, 0);
		send(ACT_EDGE, 3, 4, 65535);
		send(ACT_EDGE, 2, 4, 70000);      // weight wraps to its 16 bits
		send(ACT_EDGE, 4, 5, 1);
		send(ACT_EDGE, 2, 5, 10);
		send(ACT_EDGE, 5, 2, 3);          // cycle back to the source
		send(ACT_EDGE, 8, 1, 1);          // tail out of range: dropped
		send(ACT_EDGE, 1, 1023, 1);       // head out of range: dropped
		send(ACT_NONE, 2, 7, 1, 7, 1'b1); // unknown action: no effect
		send(ACT_QUERY, .q(7), .lastq(1'b0));
		send(ACT_QUERY, .q(1023), .lastq(1'b0)); // invalid query node
		send(ACT_QUERY, .q(5), .lastq(1'b1));
		send(ACT_EDGE, 2, 7, 1);          // stored but no rerun
		send(ACT_QUERY, .q(7), .lastq(1'b1));
		send(ACT_QUERY, .q(3), .lastq(1'b0));
		send(ACT_QUERY, .q(4), .lastq(1'b1));
		send(ACT_QUERY, .q(2), .lastq(1'b1));
		// source beyond node_count reaches nothing
		configure(1023, 8);
		send(ACT_CLEAR);
		send(ACT_EDGE, 0, 1, 1);
		send(ACT_QUERY, .q(0), .lastq(1'b1));
		// single node, zero and oversized node counts
		configure(0, 1);
		send(ACT_CLEAR);
		send(ACT_EDGE, 0, 0, 5);
		send(ACT_QUERY, .q(0), .lastq(1'b1));
		configure(0, 0);
		send(ACT_CLEAR);
		send(ACT_QUERY, .q(0), .lastq(1'b1));
		configure(1023, 2047);
		send(ACT_CLEAR);
		send(ACT_EDGE, 1023, 0, 65535);
		send(ACT_EDGE, 0, 512, 7);
		send(ACT_QUERY, .q(512), .lastq(1'b1));
	endtask

	function automatic int rand_node(int n);
		if (n > 0 && $urandom_range(0, 9) != 0)
			return $urandom_range(0, n - 1);
		return $urandom_range(0, NODE_DEPTH - 1);
	endfunction

	function automatic int rand_weight();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 255);
			2: return $urandom_range(65000, 65535);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// Random cases: clear, a small graph, then a few query sets.
	task automatic test_random_cases();
		int sent;
		int n, m, sets, len;
		sent = 0;
		while (sent < 560) begin
			case ($urandom_range(0, 5))
				0: n = 1;
				1: n = NODE_DEPTH;
				2: n = $urandom_range(0, 2047);
				default: n = $urandom_range(2, 24);
			endcase
			configure(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
				: $urandom_range(0, (n > 1) ? ((n < NODE_DEPTH ? n : NODE_DEPTH) - 1) : 0), n);
			repeat ($urandom_range(2, 4)) begin
				n = live_count();
				send(ACT_CLEAR);
				m = (n > 64) ? $urandom_range(0, 40) : $urandom_range(0, 3 * n + 4);
				for (int i = 0; i < m; i++) begin
					if ($urandom_range(0, 19) == 0)
						send(ACT_NONE, rand_node(n), rand_node(n), rand_weight(),
							rand_node(n), 1'($urandom_range(0, 1)));
					send(ACT_EDGE, rand_node(n), rand_node(n), rand_weight());
				end
				sets = $urandom_range(1, 3);
				for (int s = 0; s < sets; s++) begin
					len = $urandom_range(1, 4);
					for (int j = 0; j < len; j++)
						send(ACT_QUERY, .q(rand_node(n)), .lastq(j == len - 1));
					if ($urandom_range(0, 4) == 0)
						send(ACT_EDGE, rand_node(n), rand_node(n), rand_weight());
				end
				sent += m + sets * 3 + 1;
			end
		end
	endtask

	initial begin
		graph_clear();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_state();
		test_directed();
		test_random_cases();
		settle();
		repeat (20) @(posedge clk);
		if (!failed && ans_wr == ans_rd)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
